// ===== sv/ps2_pkg.sv =====
// shared types and constants for the ps2 pad responder
package ps2_pkg;

   localparam int unsigned MAP_FIELD_W = 5;
   localparam int unsigned MAP_FIELDS  = 12;
   localparam int unsigned MAP_W       = MAP_FIELD_W * MAP_FIELDS;
   localparam int unsigned CSR_IDX_W   = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_MAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 2'd2;

   // forced d-pad modes
   localparam logic [1:0] MODE_NONE       = 2'd0;
   localparam logic [1:0] MODE_DOWN_LR    = 2'd1;
   localparam logic [1:0] MODE_LR         = 2'd2;

   // pad bit positions of the d-pad
   localparam int unsigned PAD_UP    = 4;
   localparam int unsigned PAD_RIGHT = 5;
   localparam int unsigned PAD_DOWN  = 6;
   localparam int unsigned PAD_LEFT  = 7;

   // rotary codes
   localparam logic [1:0] ROT_STILL = 2'd0;
   localparam logic [1:0] ROT_FWD   = 2'd1;
   localparam logic [1:0] ROT_REV   = 2'd2;

   // bytes on the wire
   localparam logic [7:0] RX_START    = 8'h01;
   localparam logic [7:0] RX_POLL     = 8'h42;
   localparam logic [7:0] TX_ID       = 8'h41;
   localparam logic [7:0] TX_CMD_OK   = 8'h5A;
   localparam logic [7:0] TX_IDLE     = 8'hFF;
   localparam logic [7:0] TX_MISMATCH = 8'h00;
   localparam logic [15:0] PAD_RELEASED = 16'hFFFF;
   localparam logic [MAP_W-1:0] MAP_RESET = {MAP_W{1'b1}};

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef enum logic [2:0] {
      STEP_ID   = 3'd0,
      STEP_CMD  = 3'd1,
      STEP_LO   = 3'd2,
      STEP_HI   = 3'd3,
      STEP_TAIL = 3'd4,
      STEP_DONE = 3'd5
   } step_type;

endpackage

// ===== sv/ps2_pad_spi_responder.sv =====
// top level of the ps2 digital pad poll responder
// usage
// - req channel (valid/ready) carries two kinds of item: kind 1 is a button
//   and rotary update that rebuilds the stored active-low pad word and gives
//   no result; kind 0 is one byte received from the console and gives
//   exactly one rsp item (tx_byte to shift out next, ack flag)
// - reply order after a 0x01 byte: 0x41, 0x5A (0x00 without ack if the
//   command byte is not 0x42), pad low byte, pad high byte, 0xFF, then 0xFF
//   without ack until the next 0x01
// - csr port: write enable, index, data; 0 button map (twelve 5-bit pad
//   positions, 16 and up means unconnected), 1 forced d-pad mode,
//   2 output inversion; write only while no item is in flight
// - result: registered, it sits in the rsp register the cycle after
//   the byte item is taken
// - throughput: one item per cycle, set by the single rsp register; the
//   next item is taken in the same cycle the waiting result is taken
// - stall: while rsp_valid is high and rsp_ready low the result holds and
//   req_ready drops, so nothing is lost
// - reset: synchronous, clears the reply step, releases all pad bits and
//   loads the register reset values (all buttons unconnected)
module ps2_pad_spi_responder
   import ps2_pkg::*;
#(
   parameter int unsigned NUM_BUTTONS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [7:0]           req_rx_byte,
   input  logic [11:0]          req_buttons,
   input  logic [1:0]           req_rotary_a,
   input  logic [1:0]           req_rotary_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_ack,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MAP_W-1:0]     csr_wdata
);

   // only the first twelve buttons have map fields
   localparam int unsigned MAPPED = (NUM_BUTTONS < MAP_FIELDS) ? NUM_BUTTONS : MAP_FIELDS;

   logic [MAP_W-1:0] map_ff;
   logic [1:0]       mode_ff;
   logic             invert_ff;
   step_type         step_ff, step_in;
   logic [15:0]      pad_ff, pad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       tx_ff, tx_in;
   logic             ack_ff, ack_in;

   logic       req_fire;
   logic       byte_fire;
   logic       upd_fire;
   step_type   step_cur;
   logic [7:0] mask;
   logic [15:0] pressed_w;

   // output register frees up when empty or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign byte_fire = req_fire && (req_kind == KIND_BYTE);
   assign upd_fire  = req_fire && (req_kind == KIND_UPDATE);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = tx_ff;
   assign rsp_ack     = ack_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff    <= MAP_RESET;
         mode_ff   <= MODE_NONE;
         invert_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUTTON_MAP: map_ff    <= csr_wdata;
            CSR_MAP_MODE:   mode_ff   <= csr_wdata[1:0];
            CSR_INVERT:     invert_ff <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   // pad word build: each connected button ors in one decoded bit, then rotary and forced-mode d-pad bits
   always_comb begin
      logic [MAP_FIELD_W-1:0] pos;
      pos       = '0;
      pressed_w = '0;
      for (int i = 0; i < int'(MAPPED); i++) begin
         pos = map_ff[i*MAP_FIELD_W +: MAP_FIELD_W];
         // top bit of the field set means unconnected
         if (req_buttons[i] && !pos[MAP_FIELD_W-1]) begin
            pressed_w[pos[3:0]] = 1'b1;
         end
      end
      if (req_rotary_a != ROT_STILL) begin
         if (req_rotary_a == ROT_FWD) pressed_w[PAD_UP] = 1'b1;
         else                         pressed_w[PAD_DOWN] = 1'b1;
      end
      if (req_rotary_b != ROT_STILL) begin
         if (req_rotary_b == ROT_FWD) pressed_w[PAD_RIGHT] = 1'b1;
         else                         pressed_w[PAD_LEFT] = 1'b1;
      end
      case (mode_ff)
         MODE_DOWN_LR: begin
            pressed_w[PAD_DOWN]  = 1'b1;
            pressed_w[PAD_LEFT]  = 1'b1;
            pressed_w[PAD_RIGHT] = 1'b1;
         end
         MODE_LR: begin
            pressed_w[PAD_LEFT]  = 1'b1;
            pressed_w[PAD_RIGHT] = 1'b1;
         end
         default: ;
      endcase
   end

   assign pad_in = upd_fire ? ~pressed_w : pad_ff;

   // reply sequencer
   always_comb begin
      mask     = invert_ff ? 8'hFF : 8'h00;
      // start byte restarts the sequence before answering
      step_cur = (req_rx_byte == RX_START) ? STEP_ID : step_ff;
      tx_in    = TX_IDLE ^ mask;
      ack_in   = 1'b0;
      case (step_cur)
         STEP_ID: begin
            tx_in  = TX_ID ^ mask;
            ack_in = 1'b1;
         end
         STEP_CMD: begin
            if (req_rx_byte == RX_POLL) begin
               tx_in  = TX_CMD_OK ^ mask;
               ack_in = 1'b1;
            end else begin
               // wrong command byte: plain zero, no inversion, no ack
               tx_in  = TX_MISMATCH;
               ack_in = 1'b0;
            end
         end
         STEP_LO: begin
            tx_in  = pad_ff[7:0] ^ mask;
            ack_in = 1'b1;
         end
         STEP_HI: begin
            tx_in  = pad_ff[15:8] ^ mask;
            ack_in = 1'b1;
         end
         STEP_TAIL: begin
            tx_in  = TX_IDLE ^ mask;
            ack_in = 1'b1;
         end
         default: begin
            tx_in  = TX_IDLE ^ mask;
            ack_in = 1'b0;
         end
      endcase
      step_in = step_ff;
      if (byte_fire) begin
         case (step_cur)
            STEP_ID:   step_in = STEP_CMD;
            STEP_CMD:  step_in = STEP_LO;
            STEP_LO:   step_in = STEP_HI;
            STEP_HI:   step_in = STEP_TAIL;
            default:   step_in = STEP_DONE;
         endcase
      end
      rsp_valid_in = byte_fire || (rsp_valid_ff && !rsp_ready);
   end

   // state and handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_ID;
         pad_ff       <= PAD_RELEASED;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new byte item
   always_ff @(posedge clock) begin
      if (byte_fire) begin
         tx_ff  <= tx_in;
         ack_ff <= ack_in;
      end
   end

`ifndef SYNTH
   // the step never runs past its saturating end
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_DONE)
      else $error("reply step out of range");

   // a start byte answers with an acked result and moves to the command step
   a_restart: assert property (@(posedge clock) disable iff (reset)
      byte_fire && (req_rx_byte == RX_START)
      |=> rsp_valid_ff && ack_ff && (step_ff == STEP_CMD))
      else $error("start byte did not restart the reply");

   // an update item leaves the reply position alone
   a_update_keeps_step: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> step_ff == $past(step_ff))
      else $error("update item moved the reply step");
`endif

endmodule
